### design/grid_hillshade_assert.svh
// Assertion macros for the grid hillshade checker.
// No dependencies; included by the checker file.
`ifndef GRID_HILLSHADE_ASSERT_SVH
`define GRID_HILLSHADE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define GH_ASSERT_ALW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gh_pkg.sv
// Package for the grid hillshade block: widths, constants, register indexes.
// No dependencies.
`default_nettype none
package gh_pkg;
    localparam int DEPTH_W     = 16;
    localparam int SUN_W       = 16;
    localparam int GRAY_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int ELEV_W      = 19;
    localparam int MAG_W       = 18;
    localparam int PROD_W      = 35;
    localparam int SUNZ_W      = 24;
    localparam int N_W         = 37;
    localparam int N_POS_W     = 34;
    localparam int R_W         = 36;
    localparam int D_W         = 42;
    localparam int SQ_IN_W     = 52;
    localparam int ROOT_W      = 26;
    localparam int REM_W       = 28;
    localparam int V_W         = 32;
    localparam int DR_W        = 40;
    localparam int SQ_STEPS    = 26;
    localparam int DIV_STEPS   = 8;
    localparam int DEPTH_SCALE = 5;
    localparam int SPACING2    = 160;
    localparam int R_BASE      = 25600;

    localparam logic signed [ELEV_W-1:0] NODATA_ELEV = 19'sd24;

    localparam logic [CFG_IDX_W-1:0] CFG_SUN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_Z = 2'd2;

    localparam logic signed [SUN_W-1:0] SUN_X_RST = 16'sd8192;
    localparam logic signed [SUN_W-1:0] SUN_Y_RST = 16'sd0;
    localparam logic signed [SUN_W-1:0] SUN_Z_RST = -16'sd14189;
endpackage
`default_nettype wire

### design/grid_hillshade.sv
// Grid hillshade top level: central-difference slope, normal, sun dot product.
// Depends on gh_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready) carries the four neighbour depths of one
//   cell per transaction, Q11.4 metres, negative meaning no data.
//   Result channel (m_valid/m_ready) carries one 8-bit gray level per input
//   transaction, in input order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sun_x,
//   sun_y, sun_z at indexes 0..2; other indexes are ignored. Always ready.
//   Throughput: one transaction per cycle while the output is not stalled.
//   The 26-step square root and the 8-step quotient are fully pipelined,
//   one step per stage.
//   Reset (aresetn low, synchronous): all stage valid bits clear, the sun
//   vector returns to (0.5, 0, -0.866) in Q1.14.
//   Stall: when m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; nothing is dropped or repeated.
`default_nettype none
module grid_hillshade (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [gh_pkg::DEPTH_W-1:0]   s_east_depth,
    input  wire  [gh_pkg::DEPTH_W-1:0]   s_west_depth,
    input  wire  [gh_pkg::DEPTH_W-1:0]   s_north_depth,
    input  wire  [gh_pkg::DEPTH_W-1:0]   s_south_depth,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [gh_pkg::GRAY_W-1:0]    m_gray_level,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [gh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [gh_pkg::SUN_W-1:0]     cfg_data
);
    import gh_pkg::*;

    // Depth to elevation in 1/80 m: no data maps to +0.3 m.
    function automatic logic signed [ELEV_W-1:0] elev(input logic [DEPTH_W-1:0] d);
        logic [ELEV_W-1:0] mag;
        mag = ELEV_W'({{(ELEV_W-DEPTH_W){1'b0}}, d}) * ELEV_W'(DEPTH_SCALE);
        if (d[DEPTH_W-1]) begin
            elev = NODATA_ELEV;
        end else begin
            elev = signed'(-mag);
        end
    endfunction

    logic en;

    // Sun vector registers.
    logic signed [SUN_W-1:0] sun_x_reg, sun_y_reg, sun_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sun_x_reg <= SUN_X_RST;
            sun_y_reg <= SUN_Y_RST;
            sun_z_reg <= SUN_Z_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SUN_X: sun_x_reg <= signed'(cfg_data);
                CFG_SUN_Y: sun_y_reg <= signed'(cfg_data);
                CFG_SUN_Z: sun_z_reg <= signed'(cfg_data);
                default:   ;
            endcase
        end
    end

    // Advance every stage whenever the output register is free or drained.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: elevation differences.
    logic                     s1_vld_reg;
    logic signed [ELEV_W-1:0] p_reg, q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= elev(s_east_depth) - elev(s_west_depth);
            q_reg <= elev(s_north_depth) - elev(s_south_depth);
        end
    end

    // Stage 2: products for the dot product and the squared normal length.
    logic                     s2_vld_reg;
    logic signed [PROD_W-1:0] px_reg, qy_reg;
    logic signed [SUNZ_W-1:0] sz_reg;
    logic [R_W-1:0]           pp_reg, qq_reg;
    logic [ELEV_W-1:0]        p_abs, q_abs;

    always_comb begin
        p_abs = p_reg[ELEV_W-1] ? ELEV_W'(-p_reg) : ELEV_W'(p_reg);
        q_abs = q_reg[ELEV_W-1] ? ELEV_W'(-q_reg) : ELEV_W'(q_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= p_reg * sun_x_reg;
            qy_reg <= q_reg * sun_y_reg;
            sz_reg <= sun_z_reg * signed'(SUNZ_W'(SPACING2));
            pp_reg <= R_W'(p_abs[MAG_W-1:0]) * R_W'(p_abs[MAG_W-1:0]);
            qq_reg <= R_W'(q_abs[MAG_W-1:0]) * R_W'(q_abs[MAG_W-1:0]);
        end
    end

    // Stage 3: shade numerator and squared length.
    logic                  s3_vld_reg;
    logic signed [N_W-1:0] n_reg;
    logic [R_W-1:0]        r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg  <= N_W'(px_reg) + N_W'(qy_reg) - N_W'(sz_reg);
            r2_reg <= pp_reg + qq_reg + R_W'(R_BASE);
        end
    end

    // Square root pipeline: entry 0 holds the operand, one root bit per stage.
    logic               sq_vld_reg [0:SQ_STEPS];
    logic               sq_pos_reg [0:SQ_STEPS];
    logic [D_W-1:0]     sq_d_reg   [0:SQ_STEPS];
    logic [SQ_IN_W-1:0] sq_x_reg   [0:SQ_STEPS];
    logic [REM_W-1:0]   sq_rem_reg [0:SQ_STEPS];
    logic [ROOT_W-1:0]  sq_root_reg[0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= s3_vld_reg;
        end
    end

    // Scale the numerator by 255 as a shift and subtract.
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_pos_reg[0]  <= !n_reg[N_W-1] && (n_reg != '0);
            sq_d_reg[0]    <= D_W'({n_reg[N_POS_W-1:0], 8'b0})
                            - D_W'(n_reg[N_POS_W-1:0]);
            sq_x_reg[0]    <= {r2_reg, {(SQ_IN_W-R_W){1'b0}}};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        always_comb begin
            rem_sh = {sq_rem_reg[i], sq_x_reg[i][SQ_IN_W-1 -: 2]};
            trial  = (REM_W+2)'({sq_root_reg[i], 2'b01});
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_pos_reg[i+1]  <= sq_pos_reg[i];
                sq_d_reg[i+1]    <= sq_d_reg[i];
                sq_x_reg[i+1]    <= {sq_x_reg[i][SQ_IN_W-3:0], 2'b00};
                sq_rem_reg[i+1]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], ge};
            end
        end
    end

    // Quotient pipeline: entry 0 checks saturation, then one quotient bit per stage.
    logic              dv_vld_reg [0:DIV_STEPS];
    logic              dv_sat_reg [0:DIV_STEPS];
    logic [V_W-1:0]    dv_v_reg   [0:DIV_STEPS];
    logic [DR_W-1:0]   dv_rem_reg [0:DIV_STEPS];
    logic [GRAY_W-1:0] dv_q_reg   [0:DIV_STEPS];
    logic [V_W-1:0]    div_v;
    logic              div_sat;

    always_comb begin
        div_v   = {sq_root_reg[SQ_STEPS], 6'b0};
        div_sat = sq_d_reg[SQ_STEPS] >= D_W'({div_v, {GRAY_W{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    // Drop non-positive shade to a zero remainder so the quotient comes out zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_sat_reg[0] <= sq_pos_reg[SQ_STEPS] && div_sat;
            dv_v_reg[0]   <= div_v;
            dv_rem_reg[0] <= (sq_pos_reg[SQ_STEPS] && !div_sat)
                           ? sq_d_reg[SQ_STEPS][DR_W-1:0] : '0;
            dv_q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DR_W-1:0] vs;
        logic            ge;

        always_comb begin
            vs = DR_W'(dv_v_reg[k]) << (DIV_STEPS - 1 - k);
            ge = dv_rem_reg[k] >= vs;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_sat_reg[k+1] <= dv_sat_reg[k];
                dv_v_reg[k+1]   <= dv_v_reg[k];
                dv_rem_reg[k+1] <= ge ? dv_rem_reg[k] - vs : dv_rem_reg[k];
                dv_q_reg[k+1]   <= {dv_q_reg[k][GRAY_W-2:0], ge};
            end
        end
    end

    // Saturate when shade exceeds one.
    assign m_valid      = dv_vld_reg[DIV_STEPS];
    assign m_gray_level = dv_sat_reg[DIV_STEPS] ? {GRAY_W{1'b1}} : dv_q_reg[DIV_STEPS];

endmodule
`default_nettype wire

### design/gh_checker.sv
// Port-level checker for grid_hillshade and its bind statement.
// Depends on gh_pkg and grid_hillshade_assert.svh.
`default_nettype none
`include "grid_hillshade_assert.svh"
module gh_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire  [gh_pkg::GRAY_W-1:0]    m_gray_level,
    input wire                          cfg_ready
);
    import gh_pkg::*;

    `GH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `GH_ASSERT_NXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_gray_level), "result changed under stall")
    `GH_ASSERT_IMP(a_ready_flow, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready), "input ready not tied to output drain")
    `GH_ASSERT_ALW(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")
    `GH_ASSERT_IMP(a_cfg_ready, aclk, aresetn, 1'b1, cfg_ready, "config port not ready")

endmodule

bind grid_hillshade gh_checker u_gh_checker (.*);
`default_nettype wire
